@@ sv/lfsd_pkg.sv @@
// ---------------------------------------------------------------------------
// lfsd_pkg
// shared types and constants of the lidar frame sync decoder
// ---------------------------------------------------------------------------
`default_nettype none

package lfsd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WINDOW_D    = 3;
   localparam int unsigned FILL_W      = 2;
   localparam int unsigned DISTANCE_W  = 11;
   localparam int unsigned DIRECTION_W = 13;
   localparam int unsigned LIMIT_W     = 14;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [FILL_W-1:0]  FILL_FULL         = 2'd3;
   localparam logic [LIMIT_W-1:0] DIR_LIMIT_RESET   = 14'd5760;
   // register index taken from paddr[2]
   localparam logic               REG_DIR_LIMIT     = 1'b0;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef byte_type window_type [WINDOW_D];

   // decode of one four-byte window
   typedef struct packed {
      logic                   frame_ok;   // sync bits and checksum match
      logic                   hit;        // good frame below the direction limit
      logic [DISTANCE_W-1:0]  distance;
      logic [DIRECTION_W-1:0] direction;
      logic                   stored;
      logic                   new_sweep;
   } frame_type;

endpackage

`default_nettype wire

@@ sv/lfsd_frame_decode.sv @@
// ---------------------------------------------------------------------------
// lfsd_frame_decode
// sync check, checksum and field extraction of one four-byte window
// ---------------------------------------------------------------------------
`default_nettype none

module lfsd_frame_decode
   import lfsd_pkg::*;
(
   input  var window_type                   window,
   input  var logic [BYTE_W-1:0]            newest,
   input  var logic [LIMIT_W-1:0]           dir_limit,
   input  var logic [DIRECTION_W-1:0]       last_dir,
   input  var logic                         sweep_has_point,
   output frame_type                        frame
);

   function automatic logic [3:0] pop8(input logic [BYTE_W-1:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

   logic [3:0]             pop1;
   logic [3:0]             pop2;
   logic [3:0]             pop3;
   logic [2:0]             csum;
   logic                   sync_ok;
   logic [11:0]            raw_len;
   logic [DIRECTION_W-1:0] dir;
   logic                   below_limit;
   logic                   fresh;

   always_comb begin
      pop1    = pop8(window[1]);
      pop2    = pop8(window[2]);
      pop3    = pop8(newest);
      // only the count mod 8 matters, so the low bits of each count suffice
      csum    = pop1[2:0] + pop2[2:0] + pop3[2:0];
      sync_ok = !window[0][7] && !window[1][7] && !window[2][7] && newest[7];
      raw_len = {window[0][3:0], window[1][6:0], window[2][6]};
      dir     = {window[2][5:0], newest[6:0]};
      below_limit = {1'b0, dir} < dir_limit;
      fresh   = sweep_has_point && (dir <= last_dir);

      frame.frame_ok  = sync_ok && (csum == window[0][6:4]);
      frame.hit       = frame.frame_ok && below_limit;
      // values above 2047 read as no range
      frame.distance  = raw_len[11] ? '0 : raw_len[DISTANCE_W-1:0];
      frame.direction = dir;
      frame.stored    = !raw_len[11] && (raw_len[DISTANCE_W-1:0] != '0);
      frame.new_sweep = fresh;
   end

endmodule

`default_nettype wire

@@ sv/lidar_frame_sync_decoder.sv @@
// a byte is decoded from the input register and its point loaded into the result register
// throughput: one byte per cycle unless held by a stalled result; the sweep state loop
// closes through the decode of the byte in the input register
// a stalled result holds the input register only when that byte also yields a point
// reset: synchronous, active high; clears window fill, sweep state, valids and
// sets direction_limit to 5760
// ---------------------------------------------------------------------------
// lidar_frame_sync_decoder
// finds four-byte sample frames in a lidar byte stream and emits decoded points
// ---------------------------------------------------------------------------
`default_nettype none

module lidar_frame_sync_decoder
   import lfsd_pkg::*;
(
   input  var logic                     clock,
   input  var logic                     reset,
   // byte stream in
   input  var logic                     req_valid,
   output logic                         req_stall,
   input  var logic [7:0]               req_data_byte,
   // decoded points out
   output logic                         rsp_valid,
   input  var logic                     rsp_stall,
   output logic [DISTANCE_W-1:0]        rsp_distance,
   output logic [DIRECTION_W-1:0]       rsp_direction,
   output logic                         rsp_stored,
   output logic                         rsp_new_sweep,
   // register port
   input  var logic                     psel,
   input  var logic                     penable,
   input  var logic                     pwrite,
   input  var logic [CSR_ADDR_W-1:0]    paddr,
   input  var logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   // input register: one byte beat waiting for decode
   logic                   in_vld_ff,   in_vld_in;
   logic [BYTE_W-1:0]      in_byte_ff,  in_byte_in;

   // frame state
   window_type             window_ff,   window_in;
   logic [FILL_W-1:0]      fill_ff,     fill_in;
   logic [DIRECTION_W-1:0] last_dir_ff, last_dir_in;
   logic                   has_pt_ff,   has_pt_in;
   logic [LIMIT_W-1:0]     limit_ff,    limit_in;

   // result register
   logic                   out_vld_ff,  out_vld_in;
   frame_type              out_ff,      out_in;

   frame_type              dec;
   logic                   req_take;
   logic                   out_blocked;
   logic                   adv;
   logic                   full;
   logic                   load;
   logic                   csr_wr;

   lfsd_frame_decode u_decode (
      .window          (window_ff),
      .newest          (in_byte_ff),
      .dir_limit       (limit_ff),
      .last_dir        (last_dir_ff),
      .sweep_has_point (has_pt_ff),
      .frame           (dec)
   );

   always_comb begin
      full        = (fill_ff == FILL_FULL);
      out_blocked = out_vld_ff && rsp_stall;
      // a byte that yields no point never waits on the output side
      adv         = in_vld_ff && !(full && dec.hit && out_blocked);
      load        = adv && full && dec.hit;
      req_stall   = in_vld_ff && !adv;
      req_take    = req_valid && !req_stall;
      csr_wr      = psel && penable && pwrite && pready;

      in_vld_in   = req_take ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
      in_byte_in  = req_take ? req_data_byte : in_byte_ff;

      window_in   = window_ff;
      fill_in     = fill_ff;
      last_dir_in = last_dir_ff;
      has_pt_in   = has_pt_ff;
      if (adv) begin
         if (!full) begin
            // still filling the window
            window_in[fill_ff] = in_byte_ff;
            fill_in            = fill_ff + 2'd1;
         end else if (!dec.frame_ok) begin
            // slide by one byte
            window_in[0] = window_ff[1];
            window_in[1] = window_ff[2];
            window_in[2] = in_byte_ff;
         end else begin
            // frame used up, sweep tracking only for kept directions
            fill_in = '0;
            if (dec.hit) begin
               if (dec.new_sweep) begin
                  has_pt_in = 1'b0;
               end
               if (dec.stored) begin
                  last_dir_in = dec.direction;
                  has_pt_in   = 1'b1;
               end
            end
         end
      end

      out_vld_in = load ? 1'b1 : ((out_vld_ff && !rsp_stall) ? 1'b0 : out_vld_ff);
      out_in     = load ? dec : out_ff;

      limit_in   = (csr_wr && (paddr[2] == REG_DIR_LIMIT)) ? pwdata[LIMIT_W-1:0] : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         fill_ff     <= '0;
         last_dir_ff <= '0;
         has_pt_ff   <= 1'b0;
         limit_ff    <= DIR_LIMIT_RESET;
         out_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         fill_ff     <= fill_in;
         last_dir_ff <= last_dir_in;
         has_pt_ff   <= has_pt_in;
         limit_ff    <= limit_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      window_ff  <= window_in;
      out_ff     <= out_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_distance  = out_ff.distance;
   assign rsp_direction = out_ff.direction;
   assign rsp_stored    = out_ff.stored;
   assign rsp_new_sweep = out_ff.new_sweep;

   // register read: only direction_limit lives here
   assign prdata = (paddr[2] == REG_DIR_LIMIT) ?
                   {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff} : '0;
   assign pready = 1'b1;

   // a stalled point keeps its payload until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(out_ff))
      else $error("stalled point changed or dropped");

   // every emitted point restarts frame search
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      load |=> fill_ff == '0)
      else $error("window not cleared after a point");

   // a kept point becomes the last stored direction of the sweep
   a_stored_tracks: assert property (@(posedge clock) disable iff (reset)
      load && dec.stored |=> has_pt_ff && (last_dir_ff == $past(dec.direction)))
      else $error("sweep state not updated by stored point");

   // a held input beat keeps its byte until decoded
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !adv |=> in_vld_ff && $stable(in_byte_ff))
      else $error("input beat lost while held");

endmodule

`default_nettype wire

@@ sim/tb_lidar_frame_sync_decoder.sv @@
// ---------------------------------------------------------------------------
// tb_lidar_frame_sync_decoder
// self-checking bench: byte streams with well-formed, broken and noise frames
// go in, decoded points are checked against an in-bench decoder model
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lidar_frame_sync_decoder;
   import lfsd_pkg::*;

   // 12-bit raw distance before clamping
   localparam int unsigned RAW_DIST_W   = 12;
   localparam int unsigned MAX_DIR      = 8191;
   localparam int unsigned PHASE_BYTES  = 150;
   // a byte passes the input register and the result register before its point shows
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_GAP      = 13;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned SHOW_ERRORS  = 10;

   // register map: index taken from paddr[2]
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   typedef struct {
      logic [DISTANCE_W-1:0]  distance;
      logic [DIRECTION_W-1:0] direction;
      logic                   stored;
      logic                   new_sweep;
   } point_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_data_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [DISTANCE_W-1:0]  rsp_distance;
   logic [DIRECTION_W-1:0] rsp_direction;
   logic                   rsp_stored;
   logic                   rsp_new_sweep;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // bytes waiting to be driven in the current phase
   byte_type               stream_q[$];
   logic [LIMIT_W-1:0]     cur_limit;
   logic [DIRECTION_W-1:0] sweep_dir;
   bit                     no_gaps;
   int unsigned            hold_cycles;

   function automatic int unsigned ones_in(input byte_type b);
      int unsigned n;
      n = 0;
      for (int k = 0; k < BYTE_W; k++) n += b[k];
      return n;
   endfunction

   // decoder model plus the queue of points it has promised
   class point_scoreboard;
      window_type             win;
      logic [FILL_W-1:0]      fill;
      logic [DIRECTION_W-1:0] last_dir;
      logic                   has_point;
      logic [LIMIT_W-1:0]     limit;
      point_type              due_points[$];
      int unsigned            errors;

      function new();
         foreach (win[k]) win[k] = '0;
         fill      = '0;
         last_dir  = '0;
         has_point = 1'b0;
         limit     = DIR_LIMIT_RESET;
         errors    = 0;
      endfunction

      function void set_limit(input logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int unsigned pending();
         return due_points.size();
      endfunction

      function void take_byte(input byte_type b);
         byte_type               b0, b1, b2;
         logic [RAW_DIST_W-1:0]  len12;
         logic [DIRECTION_W-1:0] dir;
         int unsigned            sum;
         point_type              p;
         if (fill != FILL_FULL) begin
            win[fill] = b;
            fill++;
            return;
         end
         b0  = win[0];
         b1  = win[1];
         b2  = win[2];
         sum = ones_in(b1) + ones_in(b2) + ones_in(b);
         if (b0[7] || b1[7] || b2[7] || !b[7] || (sum % 8) != b0[6:4]) begin
            win[0] = b1;
            win[1] = b2;
            win[2] = b;
            return;
         end
         fill  = '0;
         len12 = {b0[3:0], b1[6:0], b2[6]};
         if (len12 > 12'h7ff) len12 = '0;
         dir = {b2[5:0], b[6:0]};
         if (dir >= limit) return;
         p.new_sweep = has_point && (dir <= last_dir);
         if (p.new_sweep) has_point = 1'b0;
         p.stored = (len12 != '0);
         if (p.stored) begin
            last_dir  = dir;
            has_point = 1'b1;
         end
         p.distance  = len12[DISTANCE_W-1:0];
         p.direction = dir;
         due_points.insert(due_points.size(), p);
      endfunction

      function void check_point(input logic [DISTANCE_W-1:0] distance,
                                input logic [DIRECTION_W-1:0] direction,
                                input logic stored, input logic new_sweep);
         point_type want;
         if (due_points.size() == 0) begin
            errors++;
            if (errors <= SHOW_ERRORS)
               $display("unexpected point: distance %0d direction %0d stored %0b new %0b",
                        distance, direction, stored, new_sweep);
            return;
         end
         want = due_points[0];
         due_points.delete(0);
         if (distance !== want.distance || direction !== want.direction ||
             stored !== want.stored || new_sweep !== want.new_sweep) begin
            errors++;
            if (errors <= SHOW_ERRORS) begin
               $display("point mismatch: expected distance %0d direction %0d stored %0b new %0b",
                        want.distance, want.direction, want.stored, want.new_sweep);
               $display("                got      distance %0d direction %0d stored %0b new %0b",
                        distance, direction, stored, new_sweep);
            end
         end
      endfunction
   endclass

   point_scoreboard sb;

   lidar_frame_sync_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_distance  (rsp_distance),
      .rsp_direction (rsp_direction),
      .rsp_stored    (rsp_stored),
      .rsp_new_sweep (rsp_new_sweep),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap before a beat: at least a quarter of draws are back to back, burst phases never wait
   function automatic int unsigned idle_draw();
      if (no_gaps || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // four frame bytes, oldest first in the top byte; checksum bits worked out here
   function automatic logic [31:0] build_frame(input logic [RAW_DIST_W-1:0] len12,
                                               input logic [DIRECTION_W-1:0] dir);
      byte_type    b1, b2, b3;
      int unsigned sum;
      b1  = {1'b0, len12[7:1]};
      b2  = {1'b0, len12[0], dir[12:7]};
      b3  = {1'b1, dir[6:0]};
      sum = ones_in(b1) + ones_in(b2) + ones_in(b3);
      return {1'b0, 3'(sum % 8), len12[11:8], b1, b2, b3};
   endfunction

   task automatic queue_byte(input byte_type b);
      stream_q.insert(stream_q.size(), b);
   endtask

   task automatic push_word(input logic [31:0] word);
      for (int k = 3; k >= 0; k--) queue_byte(word[8*k +: 8]);
   endtask

   // mostly good frames, the rest noise bytes and frames with one bit flipped
   task automatic build_random(input int unsigned n);
      logic [RAW_DIST_W-1:0] len12;
      logic [DIRECTION_W-1:0] dir;
      int unsigned            near;
      int unsigned            pick;
      while (stream_q.size() < n) begin
         case ($urandom_range(0, 9))
            0: len12 = '0;
            1: len12 = RAW_DIST_W'($urandom_range(2048, 4095));
            2: len12 = 12'h7ff;
            default: len12 = RAW_DIST_W'($urandom_range(1, 2047));
         endcase
         case ($urandom_range(0, 3))
            0: dir = DIRECTION_W'($urandom_range(0, MAX_DIR));
            1: begin
               // straddle the limit
               if (cur_limit == '0) near = 0;
               else near = cur_limit - $urandom_range(0, 1);
               dir = DIRECTION_W'((near > MAX_DIR) ? MAX_DIR : near);
            end
            default: begin
               // walk the sweep forward, wrapping now and then
               sweep_dir = sweep_dir + DIRECTION_W'($urandom_range(0, 400));
               dir = sweep_dir;
            end
         endcase
         pick = $urandom_range(0, 9);
         if (pick == 0) queue_byte(byte_type'($urandom_range(0, 255)));
         else if (pick == 1)
            push_word(build_frame(len12, dir) ^ (32'h1 << $urandom_range(0, 31)));
         else push_word(build_frame(len12, dir));
      end
   endtask

   // drive every queued byte; optionally hold off until all points are back
   task automatic send_stream(input int pause_at);
      int unsigned gap;
      for (int i = 0; i < stream_q.size(); i++) begin
         gap = idle_draw();
         if (i == pause_at) gap++;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (i == pause_at)
            while (sb.pending() != 0) @(posedge clock);
         req_valid     <= 1'b1;
         req_data_byte <= stream_q[i];
         do @(posedge clock); while (req_stall);
         sb.take_byte(stream_q[i]);
      end
      req_valid <= 1'b0;
      stream_q.delete();
   endtask

   // register write, setup phase then access phase
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == LIMIT_ADDR) sb.set_limit(data[LIMIT_W-1:0]);
   endtask

   // wait for every promised point, then let frames that give nothing drain
   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int pause_at,
                            input int unsigned hold, input bit burst);
      csr_write(LIMIT_ADDR, CSR_DATA_W'(limit));
      cur_limit = limit;
      build_random(PHASE_BYTES);
      no_gaps     = burst;
      hold_cycles = hold;
      send_stream(pause_at);
      settle();
   endtask

   // result side: random stall per beat, plus one long hold-off on request
   initial begin : point_sink
      int unsigned gap;
      rsp_stall <= 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles != 0) begin
            gap         = hold_cycles;
            hold_cycles = 0;
         end else begin
            gap = idle_draw();
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // stall is low from here, so a valid at the edge is a beat
         do @(posedge clock); while (!rsp_valid);
         sb.check_point(rsp_distance, rsp_direction, rsp_stored, rsp_new_sweep);
      end
   end

   initial begin : stimulus
      logic [31:0] word;
      sb            = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      cur_limit     = DIR_LIMIT_RESET;
      sweep_dir     = '0;
      no_gaps       = 1'b0;
      hold_cycles   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames against the limit's reset value
      push_word(build_frame(12'd1, 13'd0));       // first point of an empty sweep
      push_word(build_frame(12'hfff, 13'd5759));  // distance over range, clamped, not kept
      push_word(build_frame(12'h7ff, 13'd0));     // same direction again: new sweep
      word = build_frame(12'd10, 13'd10) ^ 32'h1000_0000;
      push_word(word);                            // checksum off by one bit
      queue_byte(8'hff);                          // noise while the window slides
      queue_byte(8'h00);
      push_word(build_frame(12'd5, 13'd5760));    // exactly at the limit, dropped
      push_word(build_frame(12'd0, 13'd0));       // zero distance that opens a sweep
      send_stream(-1);
      settle();

      // write to an unmapped index, must leave the limit alone
      csr_write(SPARE_ADDR, $urandom);

      run_phase(14'd8192, -1, 0, 1'b1);                         // everything passes, no gaps
      run_phase(14'd0, -1, 0, 1'b0);                            // everything dropped
      run_phase(LIMIT_W'($urandom_range(1, MAX_DIR)), 70, 0, 1'b0); // sender pause mid-phase
      run_phase(DIR_LIMIT_RESET, -1, LONG_HOLD, 1'b0);          // receiver backs up the block
      run_phase(14'd1, -1, 0, 1'b0);                            // only direction zero passes
      run_phase(LIMIT_W'($urandom_range(4096, 8192)), -1, 0, 1'b0);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
